### hdl/tmt_pkg.sv
// Shared constants, types and helper functions of the tile transpose engine.
package tmt_pkg;

   localparam int unsigned MaxTile  = 8;
   localparam int unsigned Lanes    = 8;
   localparam int unsigned ElemBits = 32;
   localparam int unsigned RowBits  = $clog2(Lanes);
   localparam int unsigned CntBits  = $clog2(MaxTile + 1);
   localparam int unsigned ModeBits = 2;

   localparam logic [ModeBits-1:0] ModeByte = 2'd0;
   localparam logic [ModeBits-1:0] ModeHalf = 2'd1;
   localparam logic [ModeBits-1:0] ModeWord = 2'd2;

   typedef logic [ElemBits-1:0]             elem_type;
   typedef elem_type [Lanes-1:0]            lane_vec_type;
   typedef logic [CntBits-1:0]              cnt_type;
   typedef logic [ModeBits-1:0]             mode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;
      logic [RowBits-1:0]  row_idx;
      logic                step;
      logic                last;
      cnt_type             drain_rows;
      mode_type            mode;
   } cmd_type;

   function automatic cnt_type tile_size(input mode_type mode);
      cnt_type t;
      t = (mode == ModeByte) ? cnt_type'(8) : cnt_type'(4);
      if (t > cnt_type'(MaxTile)) begin
         t = cnt_type'(MaxTile);
      end
      return t;
   endfunction

   function automatic elem_type elem_mask(input mode_type mode);
      elem_type m;
      case (mode)
         ModeByte: begin
            m = elem_type'(8'hFF);
         end
         ModeHalf: begin
            m = elem_type'(16'hFFFF);
         end
         default: begin
            m = '1;
         end
      endcase
      return m;
   endfunction

endpackage

### hdl/tmt_ctrl.sv
// Controller: row counting, tile close detection and column drain sequencing.
module tmt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [3:0]           valid_cols,
   input  logic                 last_row,
   input  logic                 csr_write,
   input  tmt_pkg::mode_type    csr_mode,
   output logic                 busy,
   output tmt_pkg::cmd_type     cmd
);

   localparam logic StIdle  = 1'b0;
   localparam logic StDrain = 1'b1;

   logic               state_ff, state_in;
   tmt_pkg::mode_type  mode_ff, mode_in;
   tmt_pkg::cnt_type   rows_ff, rows_in;
   tmt_pkg::cnt_type   ncols_ff, ncols_in;
   tmt_pkg::cnt_type   col_ff, col_in;
   tmt_pkg::cnt_type   drain_rows_ff, drain_rows_in;

   tmt_pkg::cnt_type   tsize;
   tmt_pkg::cnt_type   vc;
   tmt_pkg::cnt_type   rows_next;
   logic               accept;
   logic               close;
   logic               last_col;

   assign busy      = (state_ff == StDrain);
   assign accept    = start && !busy;
   assign tsize     = tmt_pkg::tile_size(mode_ff);
   assign rows_next = rows_ff + tmt_pkg::cnt_type'(1);
   assign close     = last_row || (rows_next >= tsize);
   assign last_col  = (col_ff == ncols_ff - tmt_pkg::cnt_type'(1));

   always_comb begin
      vc = (valid_cols == 4'd0) ? tmt_pkg::cnt_type'(1) : tmt_pkg::cnt_type'(valid_cols);
      if (vc > tsize) begin
         vc = tsize;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      rows_in       = rows_ff;
      ncols_in      = ncols_ff;
      col_in        = col_ff;
      drain_rows_in = drain_rows_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               if (close) begin
                  state_in      = StDrain;
                  ncols_in      = vc;
                  col_in        = '0;
                  drain_rows_in = rows_next;
                  rows_in       = '0;
               end else begin
                  rows_in = rows_next;
               end
            end
         end
         StDrain: begin
            col_in = col_ff + tmt_pkg::cnt_type'(1);
            if (last_col) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
      // A mode write discards any partly filled tile.
      if (csr_write) begin
         mode_in = csr_mode;
         rows_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         mode_ff       <= tmt_pkg::ModeByte;
         rows_ff       <= '0;
         ncols_ff      <= '0;
         col_ff        <= '0;
         drain_rows_ff <= '0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         rows_ff       <= rows_in;
         ncols_ff      <= ncols_in;
         col_ff        <= col_in;
         drain_rows_ff <= drain_rows_in;
      end
   end

   always_comb begin
      cmd.load       = accept;
      cmd.row_idx    = rows_ff[tmt_pkg::RowBits-1:0];
      cmd.step       = busy;
      cmd.last       = busy && last_col;
      cmd.drain_rows = drain_rows_ff;
      cmd.mode       = mode_ff;
   end

endmodule

### hdl/tmt_data.sv
// Datapath: tile row registers with column shift-out and the result register.
module tmt_data (
   input  logic                   clock,
   input  logic                   reset,
   input  tmt_pkg::cmd_type       cmd,
   input  tmt_pkg::lane_vec_type  lanes,
   output tmt_pkg::lane_vec_type  out_lanes,
   output logic                   out_valid,
   output logic                   out_last
);

   tmt_pkg::lane_vec_type  row_ff [tmt_pkg::Lanes];
   tmt_pkg::lane_vec_type  out_lanes_ff;
   logic                   out_valid_ff;
   logic                   out_last_ff;
   tmt_pkg::elem_type      mask;

   assign mask = tmt_pkg::elem_mask(cmd.mode);

   // Each row shifts toward element 0 while draining, so the head of
   // every row always holds the current column.
   always_ff @(posedge clock) begin
      for (int r = 0; r < tmt_pkg::Lanes; r++) begin
         if (cmd.load && (cmd.row_idx == tmt_pkg::RowBits'(r))) begin
            for (int k = 0; k < tmt_pkg::Lanes; k++) begin
               row_ff[r][k] <= lanes[k] & mask;
            end
         end else if (cmd.step) begin
            for (int k = 0; k < tmt_pkg::Lanes - 1; k++) begin
               row_ff[r][k] <= row_ff[r][k+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         for (int j = 0; j < tmt_pkg::Lanes; j++) begin
            out_lanes_ff[j] <= (tmt_pkg::cnt_type'(j) < cmd.drain_rows) ? row_ff[j][0] : '0;
         end
      end
      out_last_ff <= cmd.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= cmd.step;
      end
   end

   assign out_lanes = out_lanes_ff;
   assign out_valid = out_valid_ff;
   assign out_last  = out_last_ff;

endmodule

### hdl/tiled_matrix_transpose.sv
// Top level of the tile transpose engine: ports, controller and datapath.
//
//   Channel   Handshake              Carries
//   req_      start / busy           one tile row: eight lanes, column count, last flag
//   rsp_      rsp_valid strobe       one transposed column and its last-column flag
//   csr_      csr_valid / csr_ready  element mode
//
// A row that closes a tile starts a drain of one column per cycle, and the block
// stays busy until all of the tile's valid columns have been drained.
// Each result sits on the rsp_ ports for one cycle after the column leaves the
// tile registers. Reset is synchronous and leaves an empty tile in 8-bit mode.
// The receiver cannot stall: results are strobed out unconditionally.
module tiled_matrix_transpose (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_lane0,
   input  logic [31:0] req_lane1,
   input  logic [31:0] req_lane2,
   input  logic [31:0] req_lane3,
   input  logic [31:0] req_lane4,
   input  logic [31:0] req_lane5,
   input  logic [31:0] req_lane6,
   input  logic [31:0] req_lane7,
   input  logic [3:0]  req_valid_cols,
   input  logic        req_last_row,
   output logic        rsp_valid,
   output logic [31:0] rsp_out_lane0,
   output logic [31:0] rsp_out_lane1,
   output logic [31:0] rsp_out_lane2,
   output logic [31:0] rsp_out_lane3,
   output logic [31:0] rsp_out_lane4,
   output logic [31:0] rsp_out_lane5,
   output logic [31:0] rsp_out_lane6,
   output logic [31:0] rsp_out_lane7,
   output logic        rsp_last_col,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_element_mode
);

   tmt_pkg::cmd_type       cmd;
   tmt_pkg::lane_vec_type  lanes;
   tmt_pkg::lane_vec_type  out_lanes;
   logic                   csr_write;

   // Users send mode writes only while idle (unchecked); the port is always open.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign lanes[0] = req_lane0;
   assign lanes[1] = req_lane1;
   assign lanes[2] = req_lane2;
   assign lanes[3] = req_lane3;
   assign lanes[4] = req_lane4;
   assign lanes[5] = req_lane5;
   assign lanes[6] = req_lane6;
   assign lanes[7] = req_lane7;

   tmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .valid_cols (req_valid_cols),
      .last_row   (req_last_row),
      .csr_write  (csr_write),
      .csr_mode   (csr_element_mode),
      .busy       (busy),
      .cmd        (cmd)
   );

   tmt_data u_data (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .lanes     (lanes),
      .out_lanes (out_lanes),
      .out_valid (rsp_valid),
      .out_last  (rsp_last_col)
   );

   assign rsp_out_lane0 = out_lanes[0];
   assign rsp_out_lane1 = out_lanes[1];
   assign rsp_out_lane2 = out_lanes[2];
   assign rsp_out_lane3 = out_lanes[3];
   assign rsp_out_lane4 = out_lanes[4];
   assign rsp_out_lane5 = out_lanes[5];
   assign rsp_out_lane6 = out_lanes[6];
   assign rsp_out_lane7 = out_lanes[7];

   // A result only ever follows a cycle of draining.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobed without a drain cycle");

   // The last-column flag only rides on a strobed result.
   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_col |-> rsp_valid)
      else $error("last column flag without a result");

   // A row flagged as last always starts a drain.
   a_last_row_drains: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_row) |=> busy)
      else $error("closing row did not start a drain");

   // Leaving the drain coincides with the final column leaving the tile.
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_last_col)
      else $error("drain ended without a final column");

endmodule
